### hw/rtl/c3zpc_pkg.sv
// Shared constants and types of the 3x3 zero-padded convolution block.
// Used by conv3x3_zero_pad_clamp; depends on nothing else.
package c3zpc_pkg;

  // Line store geometry
  localparam int MAX_WIDTH    = 2048;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 2048;
  localparam int KERNEL_SIZE  = 3;
  localparam int NUM_TAPS     = KERNEL_SIZE * KERNEL_SIZE;

  // Field widths
  localparam int PIX_W    = 8;
  localparam int TAP_BITS = 8;
  localparam int DIM_W    = 12;
  localparam int ROW_W    = 12;
  localparam int SHIFT_W  = 3;
  localparam int OUT_W    = 20;
  localparam int PROD_W   = PIX_W + 1 + TAP_BITS;
  localparam int RSUM_W   = PROD_W + 2;
  localparam int SUM_W    = RSUM_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int UPPER_W    = 6 * TAP_BITS;
  localparam int LOWER_W    = 3 * TAP_BITS;

  // Register reset values
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [PIX_W-1:0] PIX_MAX      = 8'd255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_TAPS_UPPER_ROWS = 3'd2,
    REG_TAPS_BOTTOM_ROW = 3'd3,
    REG_FRACTION_SHIFT  = 3'd4,
    REG_CLAMP_MODE      = 3'd5
  } cfg_reg_t;

  // Frame edges that pad the window with zeros
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } pad_mask_t;

  // Per-item control from the position stage to the memory stage
  typedef struct packed {
    logic                emit;
    logic                last;
    logic                col_zero;
    logic                top_ok;
    logic                mid_ok;
    logic                win_clear;
    pad_mask_t           pad;
    logic [ADDR_W-1:0]   addr;
  } item_ctl_t;

endpackage

### hw/rtl/conv3x3_zero_pad_clamp.sv
// 3x3 convolution over a raster pixel stream with zero padding and clamp/raw output.
// Top level; depends on c3zpc_pkg.
//
// Takes one 8-bit gray pixel per clock unless stalled, in raster order (tdata = pixel,
// tuser = flush), and returns the 3x3 weighted sum for each pixel once its lower-right
// neighbor has arrived, so a frame of W x H pixels needs W+1 trailing flush transfers
// to push out its last row; the final result carries tlast. The rate is one transfer
// per clock while the output takes data; it is set by the single line memory, which
// is read when a pixel enters and written back from the stage 1 registers, with
// forwarding when the next pixel hits the same column. Both line stores share that
// memory as one 16-bit word per column; there is no clearing pass after reset, since
// padding hides every entry not yet written. Configuration registers are written
// through cfg_we/cfg_index/cfg_data while the stream is idle, which only the user ensures.
module conv3x3_zero_pad_clamp (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [c3zpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c3zpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]                          s_axis_tuser,   // [0] flush
  // result stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,   // [19:0] filtered, rest zero
  output logic                                m_axis_tlast    // frame_last
);

  localparam int AW  = c3zpc_pkg::ADDR_W;
  localparam int PW  = c3zpc_pkg::PIX_W;
  localparam int DW  = c3zpc_pkg::DIM_W;
  localparam int RW  = c3zpc_pkg::ROW_W;
  localparam int NT  = c3zpc_pkg::NUM_TAPS;
  localparam int TB  = c3zpc_pkg::TAP_BITS;
  localparam int PRW = c3zpc_pkg::PROD_W;
  localparam int RSW = c3zpc_pkg::RSUM_W;
  localparam int SW  = c3zpc_pkg::SUM_W;
  localparam int OW  = c3zpc_pkg::OUT_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DW-1:0]                      frame_width;
  logic [DW-1:0]                      frame_height;
  logic [c3zpc_pkg::UPPER_W-1:0]      taps_upper_rows;
  logic [c3zpc_pkg::LOWER_W-1:0]      taps_bottom_row;
  logic [c3zpc_pkg::SHIFT_W-1:0]      fraction_shift;
  logic                               clamp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= c3zpc_pkg::WIDTH_RESET;
      frame_height    <= c3zpc_pkg::HEIGHT_RESET;
      taps_upper_rows <= '0;
      taps_bottom_row <= '0;
      fraction_shift  <= '0;
      clamp_mode      <= 1'b1;
    end else if (cfg_we) begin
      case (c3zpc_pkg::cfg_reg_t'(cfg_index))
        c3zpc_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg_data[DW-1:0];
        c3zpc_pkg::REG_FRAME_HEIGHT:    frame_height    <= cfg_data[DW-1:0];
        c3zpc_pkg::REG_TAPS_UPPER_ROWS: taps_upper_rows <= cfg_data[c3zpc_pkg::UPPER_W-1:0];
        c3zpc_pkg::REG_TAPS_BOTTOM_ROW: taps_bottom_row <= cfg_data[c3zpc_pkg::LOWER_W-1:0];
        c3zpc_pkg::REG_FRACTION_SHIFT:  fraction_shift  <= cfg_data[c3zpc_pkg::SHIFT_W-1:0];
        c3zpc_pkg::REG_CLAMP_MODE:      clamp_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero acts as one, oversize saturates
  logic [DW-1:0] w_eff;
  logic [DW-1:0] h_eff;

  always_comb begin
    w_eff = frame_width;
    if (frame_width == '0) w_eff = DW'(1);
    else if (frame_width > DW'(c3zpc_pkg::MAX_WIDTH)) w_eff = DW'(c3zpc_pkg::MAX_WIDTH);
    h_eff = frame_height;
    if (frame_height == '0) h_eff = DW'(1);
    else if (frame_height > DW'(c3zpc_pkg::HEIGHT_LIMIT)) h_eff = DW'(c3zpc_pkg::HEIGHT_LIMIT);
  end

  // Signed taps, tap 0 in the low byte of the upper register
  logic signed [TB-1:0] taps [NT];

  always_comb begin
    for (int t = 0; t < 6; t++) begin
      taps[t] = taps_upper_rows[t*TB +: TB];
    end
    for (int t = 0; t < 3; t++) begin
      taps[6+t] = taps_bottom_row[t*TB +: TB];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: every stage moves when the output register can take data
  // ---------------------------------------------------------------------------
  logic out_valid;
  logic adv;
  logic in_xfer;

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_xfer       = s_axis_tvalid && adv;

  // ---------------------------------------------------------------------------
  // Stage 0: stream position, emit decision and padding edges
  // ---------------------------------------------------------------------------
  logic [AW-1:0] col;
  logic [RW-1:0] row;
  logic          after_last;

  logic                  restart;
  logic [AW-1:0]         ic;
  logic [RW-1:0]         ir;
  logic [DW-1:0]         cr;
  logic [DW-1:0]         cc;
  logic [DW:0]           col_inc;
  logic [AW-1:0]         col_next;
  logic [RW-1:0]         row_next;
  c3zpc_pkg::item_ctl_t  ctl0;

  always_comb begin
    restart = ({1'b0, col} >= w_eff) ||
              ({1'b0, row} >= ({1'b0, h_eff} + (DW+1)'(2)));
    ic = restart ? '0 : col;
    ir = restart ? '0 : row;

    ctl0          = '0;
    ctl0.addr     = ic;
    ctl0.col_zero = (ic == '0);
    ctl0.top_ok   = (ir >= RW'(2));
    ctl0.mid_ok   = (ir >= RW'(1));
    ctl0.win_clear = restart || after_last;

    // Column zero closes the row two rows up; others give the pixel one row up
    if (ctl0.col_zero) begin
      ctl0.emit = (ir >= RW'(2)) && ((ir - RW'(2)) < RW'(h_eff));
      cr        = DW'(ir - RW'(2));
      cc        = w_eff - DW'(1);
    end else begin
      ctl0.emit = (ir >= RW'(1)) && ((ir - RW'(1)) < RW'(h_eff));
      cr        = DW'(ir - RW'(1));
      cc        = DW'(ic) - DW'(1);
    end
    ctl0.last = ctl0.emit && (cr == h_eff - DW'(1)) && (cc == w_eff - DW'(1));

    ctl0.pad.top    = (cr == '0);
    ctl0.pad.bottom = ({1'b0, cr} + (DW+1)'(1)) >= {1'b0, h_eff};
    ctl0.pad.left   = (cc == '0);
    ctl0.pad.right  = ({1'b0, cc} + (DW+1)'(1)) >= {1'b0, w_eff};

    // Advance position; the frame's last result restarts it
    col_inc = (DW+1)'(ic) + (DW+1)'(1);
    if (ctl0.last) begin
      col_next = '0;
      row_next = '0;
    end else if (col_inc >= {1'b0, w_eff}) begin
      col_next = '0;
      row_next = ir + RW'(1);
    end else begin
      col_next = col_inc[AW-1:0];
      row_next = ir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      after_last <= 1'b0;
    end else if (in_xfer) begin
      col        <= col_next;
      row        <= row_next;
      after_last <= ctl0.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: {older row, newer row} per column, registered read
  // ---------------------------------------------------------------------------
  logic [2*PW-1:0] row_mem [c3zpc_pkg::MAX_WIDTH];
  logic [2*PW-1:0] rd_data;
  logic [2*PW-1:0] wr_data;
  logic [2*PW-1:0] fwd_data;
  logic            wr_en;

  c3zpc_pkg::item_ctl_t ctl1;
  logic                 s1_valid;
  logic [PW-1:0]        s1_pix;
  logic                 s1_fwd;

  assign wr_en = adv && s1_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[ctl1.addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_data <= row_mem[ctl0.addr];
    end
  end

  // Stage 1 registers; forward the write when the next pixel reads the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
      s1_fwd   <= s_axis_tvalid && s1_valid && (ctl0.addr == ctl1.addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ctl1     <= ctl0;
      s1_pix   <= s_axis_tuser[0] ? '0 : s_axis_tdata[PW-1:0];
      fwd_data <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: read-modify-write of the line word, window shift, window gather
  // ---------------------------------------------------------------------------
  logic [2*PW-1:0] pair;
  logic [PW-1:0]   top_pix;
  logic [PW-1:0]   mid_pix;
  logic [PW-1:0]   win      [NT];
  logic [PW-1:0]   win_base [NT];
  logic [PW-1:0]   win_new  [NT];
  logic [PW-1:0]   gath     [NT];
  logic            keep;

  always_comb begin
    pair    = s1_fwd ? fwd_data : rd_data;
    top_pix = ctl1.top_ok ? pair[2*PW-1:PW] : '0;
    mid_pix = ctl1.mid_ok ? pair[PW-1:0]    : '0;
    wr_data = {mid_pix, s1_pix};

    for (int i = 0; i < NT; i++) begin
      win_base[i] = ctl1.win_clear ? '0 : win[i];
    end
    // Shift left by one column, bring in the new column on the right
    for (int r = 0; r < 3; r++) begin
      win_new[r*3]   = win_base[r*3+1];
      win_new[r*3+1] = win_base[r*3+2];
    end
    win_new[2] = top_pix;
    win_new[5] = mid_pix;
    win_new[8] = s1_pix;

    // Column zero centers on the previous row end: old window, empty right column
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep = !((r == 0) && ctl1.pad.top)  && !((r == 2) && ctl1.pad.bottom) &&
               !((c == 0) && ctl1.pad.left) && !((c == 2) && ctl1.pad.right);
        if (ctl1.col_zero) begin
          gath[r*3+c] = (keep && (c != 2)) ? win_base[r*3+c+1] : '0;
        end else begin
          gath[r*3+c] = keep ? win_new[r*3+c] : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NT; i++) begin
        win[i] <= '0;
      end
    end else if (wr_en) begin
      for (int i = 0; i < NT; i++) begin
        win[i] <= win_new[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: tap products
  // ---------------------------------------------------------------------------
  logic                   s2_valid;
  logic                   s2_last;
  logic signed [PRW-1:0]  prod [NT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && ctl1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last <= ctl1.last;
      for (int i = 0; i < NT; i++) begin
        prod[i] <= PRW'($signed({1'b0, gath[i]}) * taps[i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: kernel row sums
  // ---------------------------------------------------------------------------
  logic                   s3_valid;
  logic                   s3_last;
  logic signed [RSW-1:0]  row_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_last <= s2_last;
      for (int r = 0; r < 3; r++) begin
        row_sum[r] <= RSW'(prod[r*3]) + RSW'(prod[r*3+1]) + RSW'(prod[r*3+2]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: total weighted sum
  // ---------------------------------------------------------------------------
  logic                  s4_valid;
  logic                  s4_last;
  logic signed [SW-1:0]  total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_last <= s3_last;
      total   <= SW'(row_sum[0]) + SW'(row_sum[1]) + SW'(row_sum[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: scale, then clamp (floor) or truncate toward zero
  // ---------------------------------------------------------------------------
  logic [SW:0]    mag;
  logic [SW:0]    mag_sh;
  logic [OW-1:0]  filtered_next;
  logic [OW-1:0]  filtered;
  logic           frame_last;

  always_comb begin
    mag    = total[SW-1] ? ((SW+1)'(0) - (SW+1)'(total)) : (SW+1)'(total);
    mag_sh = mag >> fraction_shift;
    if (clamp_mode) begin
      if (total[SW-1]) begin
        filtered_next = '0;
      end else if (mag_sh > (SW+1)'(c3zpc_pkg::PIX_MAX)) begin
        filtered_next = OW'(c3zpc_pkg::PIX_MAX);
      end else begin
        filtered_next = OW'(mag_sh);
      end
    end else begin
      filtered_next = total[SW-1] ? (OW'(0) - OW'(mag_sh)) : OW'(mag_sh);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      filtered   <= filtered_next;
      frame_last <= s4_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, filtered};
  assign m_axis_tlast  = frame_last;

endmodule
